>>> rtl/core/ffca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

  localparam int CNT_W  = 11;
  localparam int ADDR_W = 17;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_ZERO    = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_IDX_INC,
    OP_SLOT_TAKE,
    OP_FR_RD,
    OP_ALLOC_SPLIT,
    OP_ALLOC_DROP,
    OP_DN_RD,
    OP_DN_WR,
    OP_USED_DEC,
    OP_LV_RD,
    OP_LV_HIT,
    OP_POS_STEP,
    OP_POS_END,
    OP_POS_END_NEXT,
    OP_FREE_PREV,
    OP_FREE_NEXT,
    OP_UP_START,
    OP_UP_RD,
    OP_UP_WR,
    OP_INSERT,
    OP_FAIL
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SLOT,
    S_AREAD,
    S_ACHK,
    S_DN_RD,
    S_DN_WR,
    S_LV_RD,
    S_LV_CHK,
    S_PRD,
    S_PCHK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DONE
  } fsm_e;

  typedef struct packed {
    dp_op_e  op;
    status_e err;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic cnt_zero;
    logic idx_end;
    logic idx_ge_used;
    logic slot_free;
    logic fit;
    logic small_left;
    logic more_dn;
    logic live_hit;
    logic pos_before;
    logic join_next;
    logic join_prev;
    logic tbl_full;
    logic idx_gt_pos;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/first_fit_coalescing_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit heap allocator with coalescing. Raise start_i while busy_o is low to
// issue an allocate (action_i = 0, block_count_i) or a free (action_i = 1,
// address_i). busy_o stays high until the single result is shown for exactly one
// cycle with done_o high; the receiver cannot stall it, so status_o and
// granted_address_o must be taken on that cycle. Both the free segment table and
// the live allocation table are read through a registered port each, so each entry
// visited takes a read state and a check state, except the search for an empty live
// slot, which reads the valid flags directly: an allocate walks the live flags to
// the first empty slot, then the free table to the first fit, and a drop shifts
// the tail down; a free walks the live table to its match, the free table to its
// place, and an insert shifts the tail up or a merge with both neighbors shifts
// the tail down.
module first_fit_coalescing_allocator_core import ffca_pkg::*; #(
  parameter int HEAP_BYTES   = 65536,
  parameter int BLOCK_BYTES  = 64,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              action_i,
  input  wire logic [CNT_W-1:0]  block_count_i,
  input  wire logic [ADDR_W-1:0] address_i,
  output logic                   done_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [ADDR_W-1:0]      granted_address_o
);

  cmd_t  cmd;
  stat_t stat;

  ffca_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ffca_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (action_i),
    .block_count_i     (block_count_i),
    .address_i         (address_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .granted_address_o (granted_address_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result strobe outside a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> granted_address_o == '0)
    else $error("failed request returned an address");

endmodule

`default_nettype wire

>>> rtl/core/ffca_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffca_ctrl import ffca_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_IDLE;
    cmd_o.err = ST_OK;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_free) begin
          state_d = S_LV_RD;
        end else if (stat_i.cnt_zero) begin
          cmd_o.op  = OP_FAIL;
          cmd_o.err = ST_ZERO;
          state_d   = S_DONE;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (stat_i.idx_end) begin
          cmd_o.op  = OP_FAIL;
          cmd_o.err = ST_FULL;
          state_d   = S_DONE;
        end else if (stat_i.slot_free) begin
          cmd_o.op = OP_SLOT_TAKE;
          state_d  = S_AREAD;
        end else begin
          cmd_o.op = OP_IDX_INC;
        end
      end
      S_AREAD: begin
        if (stat_i.idx_ge_used) begin
          cmd_o.op  = OP_FAIL;
          cmd_o.err = ST_NOFIT;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = OP_FR_RD;
          state_d  = S_ACHK;
        end
      end
      S_ACHK: begin
        if (!stat_i.fit) begin
          cmd_o.op = OP_IDX_INC;
          state_d  = S_AREAD;
        end else if (stat_i.small_left) begin
          cmd_o.op = OP_ALLOC_DROP;
          state_d  = S_DN_RD;
        end else begin
          cmd_o.op = OP_ALLOC_SPLIT;
          state_d  = S_DONE;
        end
      end
      S_DN_RD: begin
        if (stat_i.more_dn) begin
          cmd_o.op = OP_DN_RD;
          state_d  = S_DN_WR;
        end else begin
          cmd_o.op = OP_USED_DEC;
          state_d  = S_DONE;
        end
      end
      S_DN_WR: begin
        cmd_o.op = OP_DN_WR;
        state_d  = S_DN_RD;
      end
      S_LV_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.op  = OP_FAIL;
          cmd_o.err = ST_BADADDR;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = OP_LV_RD;
          state_d  = S_LV_CHK;
        end
      end
      S_LV_CHK: begin
        if (stat_i.live_hit) begin
          cmd_o.op = OP_LV_HIT;
          state_d  = S_PRD;
        end else begin
          cmd_o.op = OP_IDX_INC;
          state_d  = S_LV_RD;
        end
      end
      S_PRD: begin
        if (stat_i.idx_ge_used) begin
          cmd_o.op = OP_POS_END;
          state_d  = S_DECIDE;
        end else begin
          cmd_o.op = OP_FR_RD;
          state_d  = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat_i.pos_before) begin
          cmd_o.op = OP_POS_STEP;
          state_d  = S_PRD;
        end else begin
          cmd_o.op = OP_POS_END_NEXT;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // merging with both neighbors folds the next entry into the previous
        if (stat_i.join_prev) begin
          cmd_o.op = OP_FREE_PREV;
          state_d  = stat_i.join_next ? S_DN_RD : S_DONE;
        end else if (stat_i.join_next) begin
          cmd_o.op = OP_FREE_NEXT;
          state_d  = S_DONE;
        end else if (stat_i.tbl_full) begin
          cmd_o.op  = OP_FAIL;
          cmd_o.err = ST_FULL;
          state_d   = S_DONE;
        end else begin
          cmd_o.op = OP_UP_START;
          state_d  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UP_WR;
        end else begin
          cmd_o.op = OP_INSERT;
          state_d  = S_DONE;
        end
      end
      S_UP_WR: begin
        cmd_o.op = OP_UP_WR;
        state_d  = S_UP_RD;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE)
    else $error("done state held longer than one cycle");

endmodule

`default_nettype wire

>>> rtl/core/ffca_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffca_dp import ffca_pkg::*; #(
  parameter int HEAP_BYTES   = 65536,
  parameter int BLOCK_BYTES  = 64,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              action_i,
  input  wire logic [CNT_W-1:0]  block_count_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [ADDR_W-1:0]      granted_address_o
);

  localparam int HW  = $clog2(HEAP_BYTES + 1);
  localparam int NW  = $clog2(((1 << CNT_W) - 1) * BLOCK_BYTES + HEADER_BYTES + 1);
  localparam int W   = (HW > NW) ? HW : NW;
  localparam int CW  = (W > ADDR_W) ? W : ADDR_W;
  localparam int IW  = $clog2(MAX_SEGMENTS + 1);
  localparam int AIW = $clog2(MAX_SEGMENTS);
  localparam logic [W-1:0]  HDR      = W'(HEADER_BYTES);
  localparam logic [W-1:0]  BLK      = W'(BLOCK_BYTES);
  localparam logic [W-1:0]  INIT_LEN = W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [IW-1:0] NSEG     = IW'(MAX_SEGMENTS);
  localparam logic [IW-1:0] ONE      = IW'(1);

  dp_op_e op;

  // request and scan registers
  logic              action_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] addr_q;
  logic [W-1:0]      need_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     pos_q;
  logic [IW-1:0]     used_q, used_d;
  logic [AIW-1:0]    slot_q;
  logic [W-1:0]      s_q, len_q, prev_s_q, prev_l_q, next_s_q, next_l_q;
  logic              has_prev_q, has_next_q;
  logic              init_q;
  status_e           res_status_q;
  logic [ADDR_W-1:0] res_addr_q;

  // free segment table
  logic [W-1:0]   fs_mem [MAX_SEGMENTS];
  logic [W-1:0]   fl_mem [MAX_SEGMENTS];
  logic [W-1:0]   fs_rd_q, fl_rd_q, fs_rd, fl_rd;
  logic           rd_init_q;
  logic           fr_re, fr_we;
  logic [IW-1:0]  fr_raddr, fr_waddr;
  logic [W-1:0]   fs_wd, fl_wd;

  // live allocation table
  logic [W-1:0]            ls_mem [MAX_SEGMENTS];
  logic [W-1:0]            ll_mem [MAX_SEGMENTS];
  logic [W-1:0]            ls_rd_q, ll_rd_q;
  logic                    lv_rd_q;
  logic [MAX_SEGMENTS-1:0] live_valid_q;
  logic                    alloc_hit, free_ok;

  logic join_next, join_prev;

  assign op = cmd_i.op;

  // entry 0 holds the whole heap until it is first written
  assign fs_rd = rd_init_q ? '0 : fs_rd_q;
  assign fl_rd = rd_init_q ? INIT_LEN : fl_rd_q;

  assign join_next = has_next_q && ((s_q + len_q) == next_s_q);
  assign join_prev = has_prev_q && ((prev_s_q + prev_l_q) == s_q);

  assign alloc_hit = (op == OP_ALLOC_SPLIT) || (op == OP_ALLOC_DROP);
  assign free_ok   = (op == OP_FREE_PREV) || (op == OP_FREE_NEXT) || (op == OP_UP_START);

  always_comb begin
    fr_re    = 1'b0;
    fr_raddr = idx_q;
    unique case (op) inside
      OP_FR_RD: fr_re = 1'b1;
      OP_DN_RD: begin
        fr_re    = 1'b1;
        fr_raddr = idx_q + ONE;
      end
      OP_UP_RD: begin
        fr_re    = 1'b1;
        fr_raddr = idx_q - ONE;
      end
      default: fr_re = 1'b0;
    endcase
  end

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = idx_q;
    fs_wd    = fs_rd;
    fl_wd    = fl_rd;
    unique case (op) inside
      OP_ALLOC_SPLIT: begin
        fr_we = 1'b1;
        fs_wd = fs_rd + need_q;
        fl_wd = fl_rd - need_q;
      end
      OP_DN_WR, OP_UP_WR: begin
        fr_we = 1'b1;
      end
      OP_FREE_PREV: begin
        fr_we    = 1'b1;
        fr_waddr = idx_q - ONE;
        fs_wd    = prev_s_q;
        fl_wd    = prev_l_q + len_q + (join_next ? next_l_q : '0);
      end
      OP_FREE_NEXT: begin
        fr_we = 1'b1;
        fs_wd = s_q;
        fl_wd = len_q + next_l_q;
      end
      OP_INSERT: begin
        fr_we = 1'b1;
        fs_wd = s_q;
        fl_wd = len_q;
      end
      default: fr_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fs_mem[fr_waddr[AIW-1:0]] <= fs_wd;
      fl_mem[fr_waddr[AIW-1:0]] <= fl_wd;
    end
    if (fr_re) begin
      fs_rd_q <= fs_mem[fr_raddr[AIW-1:0]];
      fl_rd_q <= fl_mem[fr_raddr[AIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_hit) begin
      ls_mem[slot_q] <= fs_rd;
      ll_mem[slot_q] <= need_q;
    end
    if (op == OP_LV_RD) begin
      ls_rd_q <= ls_mem[idx_q[AIW-1:0]];
      ll_rd_q <= ll_mem[idx_q[AIW-1:0]];
    end
  end

  always_comb begin
    idx_d  = idx_q;
    used_d = used_q;
    case (op)
      OP_LOAD, OP_SLOT_TAKE, OP_LV_HIT: idx_d = '0;
      OP_IDX_INC, OP_DN_WR, OP_POS_STEP: idx_d = idx_q + ONE;
      OP_UP_START: idx_d = used_q;
      OP_UP_WR: idx_d = idx_q - ONE;
      OP_USED_DEC: used_d = used_q - ONE;
      OP_INSERT: used_d = used_q + ONE;
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      used_q       <= ONE;
      init_q       <= 1'b1;
      rd_init_q    <= 1'b0;
      lv_rd_q      <= 1'b0;
      has_prev_q   <= 1'b0;
      has_next_q   <= 1'b0;
      live_valid_q <= '0;
    end else begin
      idx_q  <= idx_d;
      used_q <= used_d;
      if (fr_we && (fr_waddr == '0)) begin
        init_q <= 1'b0;
      end
      if (fr_re) begin
        rd_init_q <= init_q && (fr_raddr == '0);
      end
      if (op == OP_LV_RD) begin
        lv_rd_q <= live_valid_q[idx_q[AIW-1:0]];
      end
      if (op == OP_LV_HIT) begin
        has_prev_q <= 1'b0;
      end else if (op == OP_POS_STEP) begin
        has_prev_q <= 1'b1;
      end
      if (op == OP_POS_END) begin
        has_next_q <= 1'b0;
      end else if (op == OP_POS_END_NEXT) begin
        has_next_q <= 1'b1;
      end
      if (alloc_hit) begin
        live_valid_q[slot_q] <= 1'b1;
      end else if (free_ok) begin
        live_valid_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        action_q <= action_i;
        count_q  <= block_count_i;
        addr_q   <= address_i;
        need_q   <= W'(block_count_i) * BLK + HDR;
      end
      OP_SLOT_TAKE: slot_q <= idx_q[AIW-1:0];
      OP_LV_HIT: begin
        slot_q <= idx_q[AIW-1:0];
        s_q    <= ls_rd_q;
        len_q  <= ll_rd_q;
      end
      OP_POS_STEP: begin
        prev_s_q <= fs_rd;
        prev_l_q <= fl_rd;
      end
      OP_POS_END_NEXT: begin
        next_s_q <= fs_rd;
        next_l_q <= fl_rd;
      end
      OP_UP_START: begin
        pos_q        <= idx_q;
        res_status_q <= ST_OK;
        res_addr_q   <= '0;
      end
      OP_ALLOC_SPLIT, OP_ALLOC_DROP: begin
        res_status_q <= ST_OK;
        res_addr_q   <= ADDR_W'(fs_rd + HDR);
      end
      OP_FREE_PREV, OP_FREE_NEXT: begin
        res_status_q <= ST_OK;
        res_addr_q   <= '0;
      end
      OP_FAIL: begin
        res_status_q <= cmd_i.err;
        res_addr_q   <= '0;
      end
      default: res_addr_q <= res_addr_q;
    endcase
  end

  always_comb begin
    stat_o.is_free     = action_q;
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.idx_end     = (idx_q == NSEG);
    stat_o.idx_ge_used = (idx_q >= used_q);
    stat_o.slot_free   = !live_valid_q[idx_q[AIW-1:0]];
    stat_o.fit         = (fl_rd >= need_q);
    stat_o.small_left  = ((fl_rd - need_q) < HDR);
    stat_o.more_dn     = ({1'b0, idx_q} + {1'b0, ONE}) < {1'b0, used_q};
    stat_o.live_hit    = lv_rd_q && (CW'(ls_rd_q + HDR) == CW'(addr_q));
    stat_o.pos_before  = (fs_rd <= s_q);
    stat_o.join_next   = join_next;
    stat_o.join_prev   = join_prev;
    stat_o.tbl_full    = (used_q >= NSEG);
    stat_o.idx_gt_pos  = (idx_q > pos_q);
  end

  assign status_o          = res_status_q;
  assign granted_address_o = res_addr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= NSEG)
    else $error("free table count exceeds its depth");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ffca_pkg::*;

  localparam int HEAP     = 65536;
  localparam int BLK      = 64;
  localparam int HDR      = 24;
  localparam int SEGS     = 16;
  localparam int N_RANDOM = 525;
  localparam int LIMIT    = 400000;

  typedef struct {
    logic [STAT_W-1:0] st;
    logic [ADDR_W-1:0] ga;
  } outcome_t;

  typedef struct {
    bit      act;
    int      cnt;
    int      addr;
    bit      typed;
    status_e st;
    int      ga;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              action_i = 1'b0;
  logic [CNT_W-1:0]  block_count_i = '0;
  logic [ADDR_W-1:0] address_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [ADDR_W-1:0] granted_address_o;

  first_fit_coalescing_allocator_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .block_count_i, .address_i,
    .done_o, .status_o, .granted_address_o
  );

  always #4 clk_i = ~clk_i;

  // free segment list, sorted by start, plus the table of live allocations
  int seg_start [SEGS];
  int seg_len   [SEGS];
  int seg_cnt;
  int own_start [SEGS];
  int own_len   [SEGS];
  bit own_valid [SEGS];

  outcome_t pending[$];
  row_t     rows[$];
  int       errors = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;

  function automatic void seg_remove(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic status_e heap_alloc(int cnt, output int ga);
    int slot;
    int need;
    int s;
    ga = 0;
    if (cnt == 0) return ST_ZERO;
    slot = SEGS;
    for (int k = SEGS - 1; k >= 0; k--) if (!own_valid[k]) slot = k;
    if (slot == SEGS) return ST_FULL;
    need = cnt * BLK + HDR;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_len[i] < need) continue;
      s = seg_start[i];
      if (seg_len[i] - need < HDR) begin
        seg_remove(i);
      end else begin
        seg_start[i] = s + need;
        seg_len[i]   = seg_len[i] - need;
      end
      own_valid[slot] = 1'b1;
      own_start[slot] = s;
      own_len[slot]   = need;
      ga = s + HDR;
      return ST_OK;
    end
    return ST_NOFIT;
  endfunction

  function automatic status_e heap_release(int addr);
    int slot;
    int s;
    int len;
    int pos;
    bit jn;
    bit jp;
    slot = SEGS;
    for (int k = SEGS - 1; k >= 0; k--)
      if (own_valid[k] && own_start[k] + HDR == addr) slot = k;
    if (slot == SEGS) return ST_BADADDR;
    s   = own_start[slot];
    len = own_len[slot];
    pos = 0;
    while (pos < seg_cnt && seg_start[pos] <= s) pos++;
    jn = pos < seg_cnt && s + len == seg_start[pos];
    jp = pos > 0 && seg_start[pos-1] + seg_len[pos-1] == s;
    if (!jn && !jp && seg_cnt >= SEGS) return ST_FULL;
    own_valid[slot] = 1'b0;
    if (jn) begin
      seg_start[pos] = s;
      seg_len[pos]   = seg_len[pos] + len;
    end
    // a merge into the previous entry never needs a free slot in the list
    if (jp && jn) begin
      seg_len[pos-1] = seg_len[pos-1] + seg_len[pos];
      seg_remove(pos);
    end else if (jp) begin
      seg_len[pos-1] = seg_len[pos-1] + len;
    end else if (!jn) begin
      for (int k = seg_cnt; k > pos; k--) begin
        seg_start[k] = seg_start[k-1];
        seg_len[k]   = seg_len[k-1];
      end
      seg_start[pos] = s;
      seg_len[pos]   = len;
      seg_cnt++;
    end
    return ST_OK;
  endfunction

  task automatic issue(row_t r);
    outcome_t o;
    int ga;
    @(negedge clk_i);
    start_i       <= 1'b1;
    action_i      <= r.act;
    block_count_i <= r.cnt[CNT_W-1:0];
    address_i     <= r.addr[ADDR_W-1:0];
    do @(posedge clk_i); while (busy_o);
    if (r.act) begin
      o.st = heap_release(r.addr);
      o.ga = '0;
    end else begin
      o.st = heap_alloc(r.cnt, ga);
      o.ga = (o.st == ST_OK) ? ga[ADDR_W-1:0] : '0;
    end
    if (r.typed) begin
      o.st = r.st;
      o.ga = r.ga[ADDR_W-1:0];
    end
    pending.push_back(o);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic add_row(bit act, int cnt, int addr, bit typed, status_e st, int ga);
    row_t r;
    r = '{act, cnt, addr, typed, st, ga};
    rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: status %0d addr %0d",
                 $time, status_o, granted_address_o);
        errors++;
      end else begin
        e = pending.pop_front();
        if (status_o !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status_o);
          errors++;
        end
        if (granted_address_o !== e.ga) begin
          $display("%0t: granted_address expected %0d actual %0d",
                   $time, e.ga, granted_address_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[first_fit_coalescing_allocator_core] ERROR");
      $finish;
    end
  end

  initial begin
    row_t r;
    int   live[$];
    int   pick;
    for (int k = 0; k < SEGS; k++) begin
      seg_start[k] = 0;
      seg_len[k]   = 0;
      own_start[k] = 0;
      own_len[k]   = 0;
      own_valid[k] = 1'b0;
    end
    seg_len[0] = HEAP - HDR;
    seg_cnt    = 1;

    add_row(0, 0,      0,      1, ST_ZERO,    0);
    add_row(0, 1,      0,      1, ST_OK,      24);
    add_row(0, 1024,   0,      1, ST_NOFIT,   0);
    add_row(1, 0,      0,      1, ST_BADADDR, 0);
    add_row(1, 0,      65536,  1, ST_BADADDR, 0);
    add_row(1, 2047,   131071, 1, ST_BADADDR, 0);
    add_row(1, 0,      24,     1, ST_OK,      0);
    add_row(1, 0,      24,     1, ST_BADADDR, 0);
    add_row(0, 2047,   131071, 1, ST_NOFIT,   0);
    add_row(0, 1023,   0,      0, ST_OK,      0);  // leftover below header: whole entry
    add_row(0, 1,      0,      1, ST_NOFIT,   0);
    add_row(1, 0,      24,     0, ST_OK,      0);
    for (int i = 0; i < SEGS; i++) add_row(0, 1, 0, 0, ST_OK, 0);
    add_row(0, 1,      0,      1, ST_FULL,    0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) issue(rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = n > 450;
      live.delete();
      for (int k = 0; k < SEGS; k++) if (own_valid[k]) live.push_back(own_start[k] + HDR);
      r = '{0, 0, $urandom_range(0, 131071), 0, ST_OK, 0};
      r.cnt = $urandom_range(0, 2047);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.act = 1'b0;
        r.cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(1, 40);
      end else if (pick < 90 && live.size() > 0) begin
        r.act  = 1'b1;
        r.addr = live[$urandom_range(0, live.size() - 1)];
      end else begin
        r.act = $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 0) r.addr = $urandom_range(0, 700) * BLK + HDR;
      end
      issue(r);
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[first_fit_coalescing_allocator_core] OK");
    end else begin
      $display("[first_fit_coalescing_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

>>> first_fit_coalescing_allocator_core.f
rtl/core/ffca_pkg.sv
rtl/core/ffca_ctrl.sv
rtl/core/ffca_dp.sv
rtl/core/first_fit_coalescing_allocator_core.sv
test/testbench.sv
